@@ rtl/svm_pkg.sv @@
// Shared types and constants for the space vector modulator.
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;
    // sqrt(3)/2 and sqrt(3), both Q.30
    localparam logic [29:0] K30 = 30'd929887697;
    localparam logic [30:0] S30 = 31'd1859775393;
    // magnitude limit (sqrt(3)/2)^2 in Q.30
    localparam logic [31:0] LIM_M2 = 32'd805306368;
    // one stage per root bit
    localparam int SQ_STAGES = 31;

    typedef struct packed {
        logic signed [15:0] va;
        logic signed [15:0] vb;
        logic               lim;
    } svm_vec_t;
endpackage
`default_nettype wire

@@ rtl/svm_isqrt.sv @@
// Pipelined integer square root of m2 * 2^30, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module svm_isqrt (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [31:0]      in_m2,
    input  wire svm_pkg::svm_vec_t in_vec,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [30:0]           out_root,
    output svm_pkg::svm_vec_t     out_vec
);
    localparam int NS = svm_pkg::SQ_STAGES;
    localparam int RW = 34;

    logic [NS-1:0]     vld_reg;
    logic [NS-1:0]     rdy;
    logic [NS-1:0]     rdy_nx;
    logic [NS-1:0]     src_vld;
    logic [RW-1:0]     rem_reg  [NS];
    logic [RW-1:0]     root_reg [NS];
    logic [31:0]       m2_reg   [NS];
    svm_pkg::svm_vec_t vec_reg  [NS];
    logic [RW-1:0]     src_rem  [NS];
    logic [RW-1:0]     src_root [NS];
    logic [31:0]       src_m2   [NS];
    svm_pkg::svm_vec_t src_vec  [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic [61:0]   v_full;
            logic [RW-1:0] sh;
            logic [RW-1:0] trial;
            logic          ge;
            logic [RW-1:0] rem_next;
            logic [RW-1:0] root_next;

            if (k == 0) begin : g_first
                assign src_vld[k]  = in_valid;
                assign src_rem[k]  = '0;
                assign src_root[k] = '0;
                assign src_m2[k]   = in_m2;
                assign src_vec[k]  = in_vec;
            end else begin : g_rest
                assign src_vld[k]  = vld_reg[k-1];
                assign src_rem[k]  = rem_reg[k-1];
                assign src_root[k] = root_reg[k-1];
                assign src_m2[k]   = m2_reg[k-1];
                assign src_vec[k]  = vec_reg[k-1];
            end

            if (k == NS-1) begin : g_last
                assign rdy_nx[k] = out_ready;
            end else begin : g_mid
                assign rdy_nx[k] = rdy[k+1];
            end

            assign rdy[k]    = ~vld_reg[k] | rdy_nx[k];
            assign v_full    = {src_m2[k][31:0], 30'b0};
            assign sh        = {src_rem[k][RW-3:0], v_full[61-2*k -: 2]};
            assign trial     = {src_root[k][RW-3:0], 2'b01};
            assign ge        = sh >= trial;
            assign rem_next  = ge ? sh - trial : sh;
            assign root_next = {src_root[k][RW-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (rdy[k]) begin
                    vld_reg[k] <= src_vld[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[k] && src_vld[k]) begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    m2_reg[k]   <= src_m2[k];
                    vec_reg[k]  <= src_vec[k];
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];
    assign out_root  = root_reg[NS-1][30:0];
    assign out_vec   = vec_reg[NS-1];
endmodule
`default_nettype wire

@@ rtl/svm_div.sv @@
// Pipelined restoring divider for the limiting scale, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module svm_div #(
    parameter int W = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [30:0]      in_root,
    input  wire svm_pkg::svm_vec_t in_vec,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [W:0]            out_r,
    output svm_pkg::svm_vec_t     out_vec
);
    localparam int NW = W + 31;
    localparam int ND = W + 1;

    // dividend stage
    logic              n_vld_reg;
    logic              n_rdy;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     n_next;
    logic [30:0]       n_root_reg;
    svm_pkg::svm_vec_t n_vec_reg;
    logic [ND-1:0]     rdy;

    assign n_next = (NW'(svm_pkg::K30) << W) + NW'(in_root >> 1);
    assign n_rdy  = ~n_vld_reg | rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_vld_reg <= 1'b0;
        end else if (n_rdy) begin
            n_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_rdy && in_valid) begin
            n_reg      <= n_next;
            n_root_reg <= in_root;
            n_vec_reg  <= in_vec;
        end
    end

    // quotient stages
    logic [ND-1:0]     vld_reg;
    logic [ND-1:0]     rdy_nx;
    logic [ND-1:0]     src_vld;
    logic [31:0]       rem_reg  [ND];
    logic [W:0]        q_reg    [ND];
    logic [W:0]        nlo_reg  [ND];
    logic [30:0]       root_reg [ND];
    svm_pkg::svm_vec_t vec_reg  [ND];
    logic [31:0]       src_rem  [ND];
    logic [W:0]        src_q    [ND];
    logic [W:0]        src_nlo  [ND];
    logic [30:0]       src_root [ND];
    svm_pkg::svm_vec_t src_vec  [ND];

    genvar j;
    generate
        for (j = 0; j < ND; j++) begin : g_stage
            logic [31:0] sh;
            logic [31:0] dv;
            logic        ge;
            logic [31:0] rem_next;
            logic [W:0]  q_next;

            if (j == 0) begin : g_first
                assign src_vld[j]  = n_vld_reg;
                assign src_rem[j]  = 32'(n_reg[NW-1:W+1]);
                assign src_q[j]    = '0;
                assign src_nlo[j]  = n_reg[W:0];
                assign src_root[j] = n_root_reg;
                assign src_vec[j]  = n_vec_reg;
            end else begin : g_rest
                assign src_vld[j]  = vld_reg[j-1];
                assign src_rem[j]  = rem_reg[j-1];
                assign src_q[j]    = q_reg[j-1];
                assign src_nlo[j]  = nlo_reg[j-1];
                assign src_root[j] = root_reg[j-1];
                assign src_vec[j]  = vec_reg[j-1];
            end

            if (j == ND-1) begin : g_last
                assign rdy_nx[j] = out_ready;
            end else begin : g_mid
                assign rdy_nx[j] = rdy[j+1];
            end

            assign rdy[j]   = ~vld_reg[j] | rdy_nx[j];
            assign sh       = {src_rem[j][30:0], src_nlo[j][W-j]};
            assign dv       = {1'b0, src_root[j]};
            assign ge       = sh >= dv;
            assign rem_next = ge ? sh - dv : sh;
            if (W > 0) begin : g_q
                assign q_next = {src_q[j][W-1:0], ge};
            end else begin : g_q1
                assign q_next = ge;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[j] <= 1'b0;
                end else if (rdy[j]) begin
                    vld_reg[j] <= src_vld[j];
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[j] && src_vld[j]) begin
                    rem_reg[j]  <= rem_next;
                    q_reg[j]    <= q_next;
                    nlo_reg[j]  <= src_nlo[j];
                    root_reg[j] <= src_root[j];
                    vec_reg[j]  <= src_vec[j];
                end
            end
        end
    endgenerate

    assign in_ready  = n_rdy;
    assign out_valid = vld_reg[ND-1];
    assign out_r     = q_reg[ND-1];
    assign out_vec   = vec_reg[ND-1];
endmodule
`default_nettype wire

@@ rtl/space_vector_modulator.sv @@
// Space-vector PWM modulator: alpha-beta vector in, three phase duties out.
// Pipeline from input beat to result beat: square stage, 31-stage square root,
//   SAMPLE_BITS+2-stage divider, four arithmetic stages.
// Throughput: one vector per cycle while m_axis_tready is high; every stage is one register
//   deep, so the single-bit steps of the root and divider pipelines do not lower the rate.
// Reset: synchronous active-low aresetn clears all stage valid bits; data regs are not reset.
`timescale 1ns / 1ps
`default_nettype none
module space_vector_modulator #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] volt_alpha, [31:16] volt_beta
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c
);
    localparam int W  = SAMPLE_BITS;
    localparam int SW = W + 4;   // doubled phase voltages, X, Y
    localparam int DW = W + 6;   // 4*duty values
    localparam int EW = DW + 16;

    // ------------------------------------------------------------------
    // Stage A: register the beat and form alpha^2 + beta^2 (Q.30)
    // ------------------------------------------------------------------
    logic               a_vld_reg;
    logic               a_rdy;
    logic signed [15:0] a_va_reg;
    logic signed [15:0] a_vb_reg;
    logic [31:0]        a_m2_reg;
    logic signed [15:0] in_va;
    logic signed [15:0] in_vb;
    logic signed [31:0] sq_a;
    logic signed [31:0] sq_b;
    logic [31:0]        a_m2_next;

    assign in_va     = $signed(s_axis_tdata[15:0]);
    assign in_vb     = $signed(s_axis_tdata[31:16]);
    assign sq_a      = in_va * in_va;
    assign sq_b      = in_vb * in_vb;
    assign a_m2_next = $unsigned(sq_a) + $unsigned(sq_b);

    logic sq_in_rdy;
    assign a_rdy         = ~a_vld_reg | sq_in_rdy;
    assign s_axis_tready = a_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (a_rdy) begin
            a_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && s_axis_tvalid) begin
            a_va_reg <= in_va;
            a_vb_reg <= in_vb;
            a_m2_reg <= a_m2_next;
        end
    end

    // limit flag: magnitude above sqrt(3)/2
    svm_pkg::svm_vec_t a_vec;
    assign a_vec.va  = a_va_reg;
    assign a_vec.vb  = a_vb_reg;
    assign a_vec.lim = a_m2_reg > svm_pkg::LIM_M2;

    // ------------------------------------------------------------------
    // Magnitude and scale factor r = K30 * 2^W / mod (rounded)
    // ------------------------------------------------------------------
    logic              sq_vld;
    logic              dv_in_rdy;
    logic [30:0]       sq_root;
    svm_pkg::svm_vec_t sq_vec;

    svm_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_vld_reg),
        .in_ready  (sq_in_rdy),
        .in_m2     (a_m2_reg),
        .in_vec    (a_vec),
        .out_valid (sq_vld),
        .out_ready (dv_in_rdy),
        .out_root  (sq_root),
        .out_vec   (sq_vec)
    );

    logic              dv_vld;
    logic              b_rdy;
    logic [W:0]        dv_r;
    svm_pkg::svm_vec_t dv_vec;

    svm_div #(
        .W (W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_vld),
        .in_ready  (dv_in_rdy),
        .in_root   (sq_root),
        .in_vec    (sq_vec),
        .out_valid (dv_vld),
        .out_ready (b_rdy),
        .out_r     (dv_r),
        .out_vec   (dv_vec)
    );

    // ------------------------------------------------------------------
    // Stage B: scale component magnitudes by r, round to Q.W
    // ------------------------------------------------------------------
    logic        b_vld_reg;
    logic [W:0]  b_ma_reg;
    logic [W:0]  b_mb_reg;
    logic        b_sa_reg;
    logic        b_sb_reg;
    logic [W:0]  r_sel;
    logic [15:0] mag_a;
    logic [15:0] mag_b;
    logic [W+16:0] prod_a;
    logic [W+16:0] prod_b;
    logic [W+16:0] rnd_a;
    logic [W+16:0] rnd_b;
    logic c_rdy;

    assign r_sel  = dv_vec.lim ? dv_r : {1'b1, {W{1'b0}}};
    assign mag_a  = dv_vec.va[15] ? 16'(-dv_vec.va) : 16'(dv_vec.va);
    assign mag_b  = dv_vec.vb[15] ? 16'(-dv_vec.vb) : 16'(dv_vec.vb);
    assign prod_a = (W+17)'(mag_a) * (W+17)'(r_sel);
    assign prod_b = (W+17)'(mag_b) * (W+17)'(r_sel);
    assign rnd_a  = prod_a + (W+17)'(1 << 14);
    assign rnd_b  = prod_b + (W+17)'(1 << 14);
    assign b_rdy  = ~b_vld_reg | c_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (b_rdy) begin
            b_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_rdy && dv_vld) begin
            b_ma_reg <= rnd_a[W+15:15];
            b_mb_reg <= rnd_b[W+15:15];
            b_sa_reg <= dv_vec.va[15];
            b_sb_reg <= dv_vec.vb[15];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: signed alpha_w, T = sqrt(3) * beta_w
    // ------------------------------------------------------------------
    logic                 c_vld_reg;
    logic signed [SW-1:0] c_aw_reg;
    logic signed [SW-1:0] c_t_reg;
    logic [W+31:0]        t_prod;
    logic [W+31:0]        t_rnd;
    logic signed [SW-1:0] am;
    logic signed [SW-1:0] tmag;
    logic d_rdy;

    assign t_prod = (W+32)'(b_mb_reg) * (W+32)'(svm_pkg::S30);
    assign t_rnd  = t_prod + (W+32)'(1 << 29);
    assign am     = $signed(SW'(b_ma_reg));
    assign tmag   = $signed(SW'(t_rnd[W+31:30]));
    assign c_rdy  = ~c_vld_reg | d_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (c_rdy) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_rdy && b_vld_reg) begin
            c_aw_reg <= b_sa_reg ? -am : am;
            c_t_reg  <= b_sb_reg ? -tmag : tmag;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: doubled inverse Clarke, sector choice, X/Y and duty sums
    // ------------------------------------------------------------------
    logic                 d_vld_reg;
    logic signed [DW-1:0] d_xy_reg;
    logic signed [DW-1:0] d_sa_reg;
    logic signed [DW-1:0] d_sb_reg;
    logic signed [DW-1:0] d_sc_reg;
    logic signed [SW-1:0] ph_a;
    logic signed [SW-1:0] ph_b;
    logic signed [SW-1:0] ph_c;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [DW-1:0] xy;
    logic signed [DW-1:0] sa_next;
    logic signed [DW-1:0] sb_next;
    logic signed [DW-1:0] sc_next;
    logic e_rdy;

    assign ph_a = c_aw_reg <<< 1;
    assign ph_b = -c_aw_reg - c_t_reg;
    assign ph_c = -c_aw_reg + c_t_reg;

    always_comb begin
        sx = '0;
        sy = '0;
        if (ph_c < 0) begin
            if (ph_a < 0) begin          // sector 2
                sx = -ph_c;
                sy = -ph_a;
            end else if (ph_b < 0) begin // sector 6
                sx = -ph_b;
                sy = -ph_c;
            end else begin               // sector 1
                sx = ph_a;
                sy = ph_b;
            end
        end else if (ph_a < 0) begin
            if (ph_b <= 0) begin         // sector 4, zero B lands here
                sx = -ph_a;
                sy = -ph_b;
            end else begin               // sector 3
                sx = ph_b;
                sy = ph_c;
            end
        end else begin                   // sector 5
            sx = ph_c;
            sy = ph_a;
        end
    end

    assign xy = DW'(sx) + DW'(sy);

    always_comb begin
        sa_next = '0;
        sb_next = '0;
        sc_next = '0;
        if (ph_c < 0) begin
            if (ph_a < 0) begin
                sa_next = DW'(sx);
                sb_next = xy;
            end else if (ph_b < 0) begin
                sa_next = xy;
                sc_next = DW'(sx);
            end else begin
                sa_next = xy;
                sb_next = DW'(sy);
            end
        end else if (ph_a < 0) begin
            if (ph_b <= 0) begin
                sb_next = DW'(sx);
                sc_next = xy;
            end else begin
                sb_next = xy;
                sc_next = DW'(sy);
            end
        end else begin
            sa_next = DW'(sy);
            sc_next = xy;
        end
    end

    assign d_rdy = ~d_vld_reg | e_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (d_rdy) begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_rdy && c_vld_reg) begin
            d_xy_reg <= xy;
            d_sa_reg <= sa_next;
            d_sb_reg <= sb_next;
            d_sc_reg <= sc_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: centred zero vectors, rounding to Q0.16 and saturation;
    // this is the output register
    // ------------------------------------------------------------------
    logic                 e_vld_reg;
    logic [15:0]          e_da_reg;
    logic [15:0]          e_db_reg;
    logic [15:0]          e_dc_reg;
    logic signed [DW-1:0] z2;
    logic [15:0]          da_next;
    logic [15:0]          db_next;
    logic [15:0]          dc_next;

    function automatic logic [15:0] duty_sat(input logic signed [DW-1:0] d4);
        logic [EW-1:0] sum;
        logic [EW-1:0] q;
        begin
            sum = {$unsigned(d4), 16'b0} + (EW'(1) << (W + 1));
            q   = sum >> (W + 2);
            if (d4 <= 0) begin
                duty_sat = '0;
            end else if (q > EW'(16'hFFFF)) begin
                duty_sat = 16'hFFFF;
            end else begin
                duty_sat = q[15:0];
            end
        end
    endfunction

    assign z2      = (DW'(1) <<< (W + 1)) - d_xy_reg;
    assign da_next = duty_sat((d_sa_reg <<< 1) + z2);
    assign db_next = duty_sat((d_sb_reg <<< 1) + z2);
    assign dc_next = duty_sat((d_sc_reg <<< 1) + z2);
    assign e_rdy   = ~e_vld_reg | m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (e_rdy) begin
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_rdy && d_vld_reg) begin
            e_da_reg <= da_next;
            e_db_reg <= db_next;
            e_dc_reg <= dc_next;
        end
    end

    assign m_axis_tvalid = e_vld_reg;
    assign m_axis_tdata  = {e_dc_reg, e_db_reg, e_da_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a limited vector never gets a scale above unity
    a_scale_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_vld && dv_vec.lim) |-> (dv_r <= {1'b1, {W{1'b0}}}))
        else $error("scale factor above unity");

    // a held result is not disturbed by upstream beats
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_vld_reg && !m_axis_tready) |=>
            ($stable(e_da_reg) && $stable(e_db_reg) && $stable(e_dc_reg)))
        else $error("held result overwritten");

    // a stalled final stage stalls the stage in front of it
    a_d_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_vld_reg && !m_axis_tready && d_vld_reg) |=> (d_vld_reg && $stable(d_xy_reg)))
        else $error("pipeline stage lost a beat");
endmodule
`default_nettype wire
